/* src/id3p_pkg.sv */
// Shared types and constants for the ID3v2.3 tag text parser.
`timescale 1ns / 1ps
package id3p_pkg;

	typedef enum logic [12:0] {
		PH_SEARCH   = 13'b0000000000001,
		PH_HDR_SKIP = 13'b0000000000010,
		PH_HDR_SIZE = 13'b0000000000100,
		PH_FRAME_ID = 13'b0000000001000,
		PH_FRAME_SZ = 13'b0000000010000,
		PH_FRAME_FL = 13'b0000000100000,
		PH_ENC      = 13'b0000001000000,
		PH_TEXT     = 13'b0000010000000,
		PH_SKIP     = 13'b0000100000000,
		PH_CLOSE    = 13'b0001000000000,
		PH_END_PEND = 13'b0010000000000,
		PH_DONE     = 13'b0100000000000,
		PH_HALT     = 13'b1000000000000
	} phase_t;

	localparam logic [2:0] EV_NO_TAG    = 3'd0;
	localparam logic [2:0] EV_HDR_DONE  = 3'd1;
	localparam logic [2:0] EV_TEXT_CHAR = 3'd2;
	localparam logic [2:0] EV_FRAME_END = 3'd3;
	localparam logic [2:0] EV_TRACK     = 3'd4;
	localparam logic [2:0] EV_TAG_END   = 3'd5;
	localparam logic [2:0] EV_ERROR     = 3'd6;

	localparam logic [1:0] ERR_NONE     = 2'd0;
	localparam logic [1:0] ERR_FRAME_ID = 2'd1;
	localparam logic [1:0] ERR_ENCODING = 2'd2;

	localparam logic [1:0] ENC_LATIN1 = 2'd0;
	localparam logic [1:0] ENC_UCS2   = 2'd1;
	localparam logic [1:0] ENC_UTF8   = 2'd3;

	localparam logic [2:0] SLOT_TRACK = 3'd4;
	localparam logic [20:0] REPLACEMENT = 21'h00FFFD;

	typedef logic [31:0] fourcc_t;
	localparam fourcc_t TEXT_IDS [5] = '{
		32'h54414C42, 32'h54434F4D, 32'h54495432, 32'h54504531, 32'h5452434B
	};
	localparam fourcc_t SKIP_IDS [17] = '{
		32'h41504943, 32'h434F4D4D, 32'h47454F42, 32'h504F504D, 32'h50524956,
		32'h53594C54, 32'h54434F4E, 32'h54434F50, 32'h54454E43, 32'h54504532,
		32'h54505542, 32'h54535345, 32'h54585858, 32'h54594552, 32'h574F4146,
		32'h574F4152, 32'h574F4153
	};

	// One result word
	typedef struct packed {
		logic [2:0]  kind;
		logic [2:0]  slot;
		logic [20:0] cp;
		logic [27:0] size;
		logic [7:0]  track;
		logic [1:0]  err;
	} result_t;

endpackage

/* src/id3p_frame_class.sv */
// Frame id lookup: text slot, skip list or unknown.
`timescale 1ns / 1ps
module id3p_frame_class import id3p_pkg::*; (
	input  fourcc_t    frame_id,
	output logic       is_text,
	output logic [2:0] text_slot,
	output logic       is_skip
);

	// Compare against both id tables
	always_comb begin
		is_text = 1'b0;
		text_slot = 3'd0;
		is_skip = 1'b0;
		for (int i = 0; i < 5; i++) begin
			if (frame_id == TEXT_IDS[i]) begin
				is_text = 1'b1;
				text_slot = 3'(i);
			end
		end
		for (int i = 0; i < 17; i++) begin
			if (frame_id == SKIP_IDS[i]) is_skip = 1'b1;
		end
	end

endmodule

/* src/id3v2_tag_text_parser.sv */
// Top level of the ID3v2.3 tag text parser: byte-wise header, frame and text decode.
`timescale 1ns / 1ps
//  channel  direction  payload                                       handshake
//  in       input      data_byte, stream_start                       in_valid / in_ready
//  out      output     event_kind, field_slot, code_point, tag_size,  out_valid / out_ready
//                      track_value, error_code
// One byte is taken per cycle while in_ready is high; its result word, if any, is registered at the accepting
// edge and shows on the outputs from the next cycle.
// Throughput is one byte per clock while in_ready is high, set by the single parse-state update per byte.
// arst_n clears the parse state to header search and empties the output register.
// in_ready falls only while a result word is held and out_ready is low.
module id3v2_tag_text_parser import id3p_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [7:0]  data_byte,
	input  logic        stream_start,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [2:0]  event_kind,
	output logic [2:0]  field_slot,
	output logic [20:0] code_point,
	output logic [27:0] tag_size,
	output logic [7:0]  track_value,
	output logic [1:0]  error_code
);

	phase_t      phase_q;
	logic [2:0]  cnt_q;
	logic [33:0] tag_left_q;
	fourcc_t     fid_q;
	logic [31:0] frame_left_q;
	logic [1:0]  enc_q;
	logic        be_q;
	logic [7:0]  low_q;
	logic [20:0] acc_q;
	logic [1:0]  pend_q;
	logic [7:0]  track_q;
	logic [2:0]  slot_q;
	logic        stop_q;

	phase_t      phase_d;
	logic [2:0]  cnt_d;
	logic [33:0] tag_left_d;
	fourcc_t     fid_d;
	logic [31:0] frame_left_d;
	logic [1:0]  enc_d;
	logic        be_d;
	logic [7:0]  low_d;
	logic [20:0] acc_d;
	logic [1:0]  pend_d;
	logic [7:0]  track_d;
	logic [2:0]  slot_d;
	logic        stop_d;

	logic        res_vld;
	result_t     res;
	logic        out_vld_q;
	result_t     out_q;

	logic        is_text, is_skip;
	logic [2:0]  text_slot;

	logic        accept;
	assign in_ready = !out_vld_q || out_ready;
	assign accept = in_valid && in_ready;

	id3p_frame_class u_class (
		.frame_id (fid_q),
		.is_text  (is_text),
		.text_slot(text_slot),
		.is_skip  (is_skip)
	);

	// Next-state and result logic for one byte
	always_comb begin
		logic [7:0]  b;
		logic [2:0]  k;
		logic [33:0] tag_dec;
		logic        got;
		logic [20:0] cp;
		logic [20:0] acc_n;
		logic [7:0]  mul;
		phase_t      ph;
		b = data_byte;
		ph = phase_q;
		cnt_d = cnt_q;
		tag_left_d = tag_left_q;
		fid_d = fid_q;
		frame_left_d = frame_left_q;
		enc_d = enc_q;
		be_d = be_q;
		low_d = low_q;
		acc_d = acc_q;
		pend_d = pend_q;
		track_d = track_q;
		slot_d = slot_q;
		stop_d = stop_q;
		if (stream_start) begin
			ph = PH_SEARCH;
			cnt_d = '0; tag_left_d = '0; fid_d = '0; frame_left_d = '0;
			enc_d = '0; be_d = 1'b0; low_d = '0; acc_d = '0; pend_d = '0;
			track_d = '0; slot_d = '0; stop_d = 1'b0;
		end
		phase_d = ph;
		res_vld = 1'b0;
		res = '0;
		got = 1'b0;
		cp = '0;
		acc_n = '0;
		mul = '0;
		tag_dec = (tag_left_d != 34'd0) ? tag_left_d - 34'd1 : tag_left_d;
		k = (cnt_d > 3'd2) ? 3'd2 : cnt_d;
		case (ph)
			PH_SEARCH: begin
				if (b != ((k == 3'd0) ? 8'h49 : (k == 3'd1) ? 8'h44 : 8'h33)) begin
					phase_d = PH_DONE;
					res_vld = 1'b1;
					res.kind = EV_NO_TAG;
				end else if (k == 3'd2) begin
					cnt_d = '0;
					phase_d = PH_HDR_SKIP;
				end else begin
					cnt_d = k + 3'd1;
				end
			end
			PH_HDR_SKIP: begin
				if (cnt_d >= 3'd2) begin
					cnt_d = '0;
					tag_left_d = '0;
					phase_d = PH_HDR_SIZE;
				end else begin
					cnt_d = cnt_d + 3'd1;
				end
			end
			PH_HDR_SIZE: begin
				tag_left_d = {6'd0, tag_left_d[20:0], b[6:0]};
				if (cnt_d >= 3'd3) begin
					cnt_d = '0;
					fid_d = '0;
					phase_d = (tag_left_d == 34'd0) ? PH_END_PEND : PH_FRAME_ID;
					res_vld = 1'b1;
					res.kind = EV_HDR_DONE;
					res.size = tag_left_d[27:0];
				end else begin
					cnt_d = cnt_d + 3'd1;
				end
			end
			PH_FRAME_ID: begin
				tag_left_d = tag_dec;
				fid_d = {fid_d[23:0], b};
				if (cnt_d >= 3'd3) begin
					cnt_d = '0;
					if (fid_d == 32'd0) begin
						phase_d = PH_DONE;
						res_vld = 1'b1;
						res.kind = EV_TAG_END;
					end else begin
						frame_left_d = '0;
						phase_d = PH_FRAME_SZ;
					end
				end else begin
					cnt_d = cnt_d + 3'd1;
				end
			end
			PH_FRAME_SZ: begin
				tag_left_d = tag_dec;
				frame_left_d = {frame_left_d[23:0], b};
				if (cnt_d >= 3'd3) begin
					cnt_d = '0;
					phase_d = PH_FRAME_FL;
				end else begin
					cnt_d = cnt_d + 3'd1;
				end
			end
			PH_FRAME_FL: begin
				tag_left_d = tag_dec;
				if (cnt_d >= 3'd1) begin
					cnt_d = '0;
					track_d = '0;
					stop_d = 1'b0;
					if (is_text) begin
						slot_d = text_slot;
						phase_d = (frame_left_d == 32'd0) ? PH_CLOSE : PH_ENC;
					end else if (is_skip) begin
						slot_d = '0;
						phase_d = (frame_left_d == 32'd0) ? PH_CLOSE : PH_SKIP;
					end else begin
						phase_d = PH_HALT;
						res_vld = 1'b1;
						res.kind = EV_ERROR;
						res.err = ERR_FRAME_ID;
					end
				end else begin
					cnt_d = cnt_d + 3'd1;
				end
			end
			PH_ENC: begin
				tag_left_d = tag_dec;
				frame_left_d = frame_left_d - 32'd1;
				if (b != 8'd0 && b != 8'd1 && b != 8'd3) begin
					phase_d = PH_HALT;
					res_vld = 1'b1;
					res.kind = EV_ERROR;
					res.err = ERR_ENCODING;
				end else begin
					enc_d = b[1:0];
					cnt_d = '0;
					pend_d = '0;
					acc_d = '0;
					phase_d = (frame_left_d == 32'd0) ? PH_CLOSE : PH_TEXT;
				end
			end
			PH_TEXT: begin
				tag_left_d = tag_dec;
				frame_left_d = frame_left_d - 32'd1;
				case (enc_d)
					ENC_LATIN1: begin
						got = 1'b1;
						cp = {13'd0, b};
					end
					ENC_UCS2: begin
						case (cnt_d)
							3'd0: begin low_d = b; cnt_d = 3'd1; end
							3'd1: begin
								be_d = (low_d == 8'hFE) && (b == 8'hFF);
								cnt_d = 3'd2;
							end
							3'd2: begin low_d = b; cnt_d = 3'd3; end
							default: begin
								got = 1'b1;
								cp = be_d ? {5'd0, low_d, b} : {5'd0, b, low_d};
								cnt_d = 3'd2;
							end
						endcase
					end
					ENC_UTF8: begin
						if (pend_d != 2'd0 && b[7:6] == 2'b10) begin
							acc_n = {acc_d[14:0], b[5:0]};
							acc_d = acc_n;
							pend_d = pend_d - 2'd1;
							if (pend_d == 2'd0) begin
								got = 1'b1;
								cp = (acc_n > 21'h10FFFF) ? REPLACEMENT : acc_n;
							end
						end else begin
							pend_d = 2'd0;
							if (!b[7]) begin
								got = 1'b1;
								cp = {13'd0, b};
							end else if (b[7:5] == 3'b110) begin
								acc_d = {16'd0, b[4:0]}; pend_d = 2'd1;
							end else if (b[7:4] == 4'b1110) begin
								acc_d = {17'd0, b[3:0]}; pend_d = 2'd2;
							end else if (b[7:3] == 5'b11110) begin
								acc_d = {18'd0, b[2:0]}; pend_d = 2'd3;
							end else begin
								got = 1'b1;
								cp = REPLACEMENT;
							end
						end
					end
					default: ;
				endcase
				if (frame_left_d == 32'd0) phase_d = PH_CLOSE;
				if (got) begin
					if (slot_d == SLOT_TRACK) begin
						if (!stop_d) begin
							if (cp >= 21'h30 && cp <= 21'h39) begin
								mul = {track_d[6:0], 1'b0} + {track_d[4:0], 3'b000};
								track_d = mul + (cp[7:0] - 8'h30);
							end else begin
								stop_d = 1'b1;
							end
						end
					end else begin
						res_vld = 1'b1;
						res.kind = EV_TEXT_CHAR;
						res.slot = slot_d;
						res.cp = cp;
					end
				end
			end
			PH_SKIP: begin
				tag_left_d = tag_dec;
				frame_left_d = frame_left_d - 32'd1;
				if (frame_left_d == 32'd0) phase_d = PH_CLOSE;
			end
			PH_CLOSE: begin
				if (tag_left_d == 34'd0) begin
					phase_d = PH_END_PEND;
				end else begin
					tag_left_d = tag_dec;
					fid_d = {24'd0, b};
					cnt_d = 3'd1;
					phase_d = PH_FRAME_ID;
				end
				res_vld = 1'b1;
				res.slot = slot_d;
				if (slot_d == SLOT_TRACK) begin
					res.kind = EV_TRACK;
					res.track = track_d;
				end else begin
					res.kind = EV_FRAME_END;
				end
			end
			PH_END_PEND: begin
				phase_d = PH_DONE;
				res_vld = 1'b1;
				res.kind = EV_TAG_END;
			end
			default: ;
		endcase
	end

	// Parse state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_SEARCH;
			cnt_q <= '0;
			tag_left_q <= '0;
			fid_q <= '0;
			frame_left_q <= '0;
			enc_q <= '0;
			be_q <= 1'b0;
			low_q <= '0;
			acc_q <= '0;
			pend_q <= '0;
			track_q <= '0;
			slot_q <= '0;
			stop_q <= 1'b0;
		end else if (accept) begin
			phase_q <= phase_d;
			cnt_q <= cnt_d;
			tag_left_q <= tag_left_d;
			fid_q <= fid_d;
			frame_left_q <= frame_left_d;
			enc_q <= enc_d;
			be_q <= be_d;
			low_q <= low_d;
			acc_q <= acc_d;
			pend_q <= pend_d;
			track_q <= track_d;
			slot_q <= slot_d;
			stop_q <= stop_d;
		end
	end

	// Output word register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q <= 1'b0;
		end else if (in_ready) begin
			out_vld_q <= accept && res_vld;
		end
	end

	always_ff @(posedge clk) begin
		if (accept && res_vld) begin
			out_q <= res;
		end
	end

	assign out_valid = out_vld_q;
	assign event_kind = out_q.kind;
	assign field_slot = out_q.slot;
	assign code_point = out_q.cp;
	assign tag_size = out_q.size;
	assign track_value = out_q.track;
	assign error_code = out_q.err;

endmodule
